// ===== rtl/core/qufi_pkg.sv =====
// Shared types and codes for the queue with urgent front insert.
package qufi_pkg;

	// command codes
	localparam logic [1:0] CMD_ENQ  = 2'd0;
	localparam logic [1:0] CMD_URG  = 2'd1;
	localparam logic [1:0] CMD_DEQ  = 2'd2;
	localparam logic [1:0] CMD_PEEK = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// datapath actions, one per cycle
	localparam logic [3:0] ACT_NONE        = 4'd0;
	localparam logic [3:0] ACT_REJECT      = 4'd1;
	localparam logic [3:0] ACT_REAR        = 4'd2;
	localparam logic [3:0] ACT_FRONT       = 4'd3;
	localparam logic [3:0] ACT_EMPTY       = 4'd4;
	localparam logic [3:0] ACT_RD_HEAD     = 4'd5;
	localparam logic [3:0] ACT_RD_DONE     = 4'd6;
	localparam logic [3:0] ACT_SHIFT_START = 4'd7;
	localparam logic [3:0] ACT_SHIFT       = 4'd8;
	localparam logic [3:0] ACT_SHIFT_END   = 4'd9;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] item_id;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_id;
		logic [7:0]  entry_count;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic       accept;
		logic [3:0] act;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       empty;
		logic       full;
		logic       head_zero;
		logic       rptr_zero;
	} sts_t;

endpackage

// ===== rtl/core/qufi_ctrl.sv =====
// Control state machine for the queue with urgent front insert.
module qufi_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  qufi_pkg::sts_t sts,
	output logic           busy,
	output qufi_pkg::ctl_t ctl
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_LAST  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d    = state_q;
		ctl.accept = 1'b0;
		ctl.act    = qufi_pkg::ACT_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.accept = 1'b1;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				priority if ((sts.cmd == qufi_pkg::CMD_ENQ || sts.cmd == qufi_pkg::CMD_URG)
						&& sts.full) begin
					ctl.act = qufi_pkg::ACT_REJECT;
				end else if (sts.cmd == qufi_pkg::CMD_ENQ) begin
					ctl.act = qufi_pkg::ACT_REAR;
				end else if (sts.cmd == qufi_pkg::CMD_URG && (sts.empty || !sts.head_zero)) begin
					ctl.act = qufi_pkg::ACT_FRONT;
				end else if (sts.cmd == qufi_pkg::CMD_URG) begin
					ctl.act = qufi_pkg::ACT_SHIFT_START;
					state_d = S_SHIFT;
				end else if (sts.empty) begin
					ctl.act = qufi_pkg::ACT_EMPTY;
				end else begin
					ctl.act = qufi_pkg::ACT_RD_HEAD;
					state_d = S_READ;
				end
			end
			S_READ: begin
				ctl.act = qufi_pkg::ACT_RD_DONE;
				state_d = S_IDLE;
			end
			S_SHIFT: begin
				ctl.act = qufi_pkg::ACT_SHIFT;
				if (sts.rptr_zero) begin
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				ctl.act = qufi_pkg::ACT_SHIFT_END;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/qufi_dpath.sv =====
// Datapath: slot memory, head/tail indices, shift pointer and result register.
module qufi_dpath #(
	parameter int QUEUE_DEPTH = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  qufi_pkg::item_t   item,
	input  qufi_pkg::ctl_t    ctl,
	output qufi_pkg::sts_t    sts,
	output logic              done,
	output qufi_pkg::result_t result
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

	logic [15:0]      slots_q [QUEUE_DEPTH];
	logic [15:0]      rdata_q;
	logic [1:0]       cmd_q;
	logic [15:0]      id_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic             empty_q;
	logic [IDX_W-1:0] rptr_q;
	logic             done_q;
	logic [1:0]       status_q;
	logic [15:0]      out_id_q;

	logic             mem_we;
	logic [IDX_W-1:0] waddr;
	logic [15:0]      wdata;
	logic             mem_re;
	logic [IDX_W-1:0] raddr;
	logic [IDX_W:0]   span;

	assign sts.cmd       = cmd_q;
	assign sts.empty     = empty_q;
	assign sts.full      = !empty_q && (tail_q == LAST_IDX);
	assign sts.head_zero = (head_q == '0);
	assign sts.rptr_zero = (rptr_q == '0);

	// memory port selection
	always_comb begin
		mem_we = 1'b0;
		waddr  = '0;
		wdata  = id_q;
		mem_re = 1'b0;
		raddr  = head_q;
		unique case (ctl.act)
			qufi_pkg::ACT_REAR: begin
				mem_we = 1'b1;
				waddr  = empty_q ? '0 : tail_q + 1'b1;
			end
			qufi_pkg::ACT_FRONT: begin
				mem_we = 1'b1;
				waddr  = empty_q ? '0 : head_q - 1'b1;
			end
			qufi_pkg::ACT_RD_HEAD: begin
				mem_re = 1'b1;
				raddr  = head_q;
			end
			qufi_pkg::ACT_SHIFT_START: begin
				mem_re = 1'b1;
				raddr  = tail_q;
			end
			qufi_pkg::ACT_SHIFT: begin
				mem_we = 1'b1;
				waddr  = rptr_q + 1'b1;
				wdata  = rdata_q;
				mem_re = (rptr_q != '0);
				raddr  = rptr_q - 1'b1;
			end
			qufi_pkg::ACT_SHIFT_END: begin
				mem_we = 1'b1;
				waddr  = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slots_q[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= slots_q[raddr];
		end
	end

	// captured command word, shift pointer and result payload
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q <= item.cmd;
			id_q  <= item.item_id;
		end
		if (ctl.act == qufi_pkg::ACT_SHIFT_START) begin
			rptr_q <= tail_q;
		end else if (ctl.act == qufi_pkg::ACT_SHIFT && rptr_q != '0) begin
			rptr_q <= rptr_q - 1'b1;
		end
		unique case (ctl.act)
			qufi_pkg::ACT_REJECT: begin
				status_q <= qufi_pkg::ST_FULL;
				out_id_q <= '0;
			end
			qufi_pkg::ACT_EMPTY: begin
				status_q <= qufi_pkg::ST_EMPTY;
				out_id_q <= '0;
			end
			qufi_pkg::ACT_REAR, qufi_pkg::ACT_FRONT, qufi_pkg::ACT_SHIFT_END: begin
				status_q <= qufi_pkg::ST_OK;
				out_id_q <= '0;
			end
			qufi_pkg::ACT_RD_DONE: begin
				status_q <= qufi_pkg::ST_OK;
				out_id_q <= rdata_q;
			end
			default: begin
			end
		endcase
	end

	// indices and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			done_q <= (ctl.act == qufi_pkg::ACT_REJECT || ctl.act == qufi_pkg::ACT_EMPTY
				|| ctl.act == qufi_pkg::ACT_REAR || ctl.act == qufi_pkg::ACT_FRONT
				|| ctl.act == qufi_pkg::ACT_RD_DONE || ctl.act == qufi_pkg::ACT_SHIFT_END);
			unique case (ctl.act)
				qufi_pkg::ACT_REAR: begin
					if (empty_q) begin
						head_q  <= '0;
						tail_q  <= '0;
						empty_q <= 1'b0;
					end else begin
						tail_q <= tail_q + 1'b1;
					end
				end
				qufi_pkg::ACT_FRONT: begin
					if (empty_q) begin
						head_q  <= '0;
						tail_q  <= '0;
						empty_q <= 1'b0;
					end else begin
						head_q <= head_q - 1'b1;
					end
				end
				qufi_pkg::ACT_RD_DONE: begin
					if (cmd_q == qufi_pkg::CMD_DEQ) begin
						if (head_q == tail_q) begin
							head_q  <= '0;
							tail_q  <= '0;
							empty_q <= 1'b1;
						end else begin
							head_q <= head_q + 1'b1;
						end
					end
				end
				qufi_pkg::ACT_SHIFT_END: begin
					tail_q <= tail_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// count follows the indices, which hold still while the result is shown
	assign span = {1'b0, tail_q} - {1'b0, head_q} + 1'b1;

	assign done               = done_q;
	assign result.status      = status_q;
	assign result.out_id      = out_id_q;
	assign result.entry_count = empty_q ? 8'd0 : 8'(span);

endmodule

// ===== rtl/core/queue_with_urgent_front_insert.sv =====
// Top level: linear-array ID queue with rear enqueue, urgent front insert, dequeue and peek.
// Enqueue, front insert into a free slot, rejected or empty commands act in the execute state;
//   dequeue and peek add a read state (registered memory read); an urgent insert with head at
//   slot 0 shifts one entry per cycle through the shift and last states before its result.
// Throughput: a new command is taken in the cycle its predecessor's one-cycle done strobe
//   is shown; the receiver cannot stall. Reset (arst_n low) empties the queue.
module queue_with_urgent_front_insert #(
	parameter int QUEUE_DEPTH = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  qufi_pkg::item_t   item,
	output logic              done,
	output qufi_pkg::result_t result
);

	qufi_pkg::ctl_t ctl;   // per-cycle action from the controller
	qufi_pkg::sts_t sts;   // queue state seen by the controller

	qufi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.ctl    (ctl)
	);

	qufi_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctl    (ctl),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

	// an accepted word always makes the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	// every result follows a busy cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// a non-ok result carries no ID
	a_nonok_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != qufi_pkg::ST_OK) |-> (result.out_id == 16'd0))
		else $error("rejected or empty result carries an ID");

	// an empty result reports no entries
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == qufi_pkg::ST_EMPTY) |-> (result.entry_count == 8'd0))
		else $error("empty status with nonzero count");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the linear-array ID queue with urgent front insert.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUEUE_DEPTH  = 128;
	localparam int RANDOM_WORDS = 1530;
	// Slowest command is a shifting front insert.
	localparam int SETTLE_CYCLES = QUEUE_DEPTH + 16;

	// Phase flavors for the random part; each one biases the command mix.
	typedef enum int {
		MIX_FILL,
		MIX_DRAIN,
		MIX_EVEN,
		MIX_URGENT
	} mix_e;

	// Keeps a private copy of the queue, predicts the result of each accepted
	// word and compares it with what the block returns.
	class front_queue_predictor;
		logic [15:0]       slot_mem [QUEUE_DEPTH];
		int unsigned       head_idx;
		int unsigned       tail_idx;
		bit                held_none;
		qufi_pkg::result_t awaited_results [$];
		int                mismatches;

		function new();
			head_idx   = 0;
			tail_idx   = 0;
			held_none  = 1'b1;
			mismatches = 0;
			foreach (slot_mem[i])
				slot_mem[i] = '0;
		endfunction

		task report_mismatch(string what);
			mismatches++;
			$display("[%0t] MISMATCH: %s", $realtime, what);
		endtask

		function int pending();
			return awaited_results.size();
		endfunction

		// Applies one accepted command to the private queue and queues its result.
		function void note_command(qufi_pkg::item_t w);
			qufi_pkg::result_t r;
			int unsigned i;
			r.status = qufi_pkg::ST_OK;
			r.out_id = '0;
			case (w.cmd)
				qufi_pkg::CMD_ENQ, qufi_pkg::CMD_URG: begin
					if (!held_none && tail_idx == QUEUE_DEPTH - 1) begin
						r.status = qufi_pkg::ST_FULL;
					end else if (held_none) begin
						head_idx    = 0;
						tail_idx    = 0;
						held_none   = 1'b0;
						slot_mem[0] = w.item_id;
					end else if (w.cmd == qufi_pkg::CMD_ENQ) begin
						tail_idx++;
						slot_mem[tail_idx] = w.item_id;
					end else if (head_idx > 0) begin
						// a freed front slot is reused
						head_idx--;
						slot_mem[head_idx] = w.item_id;
					end else begin
						// head at slot 0: every entry moves up one slot
						for (i = tail_idx + 1; i > head_idx; i--)
							slot_mem[i] = slot_mem[i - 1];
						tail_idx++;
						slot_mem[head_idx] = w.item_id;
					end
				end
				qufi_pkg::CMD_DEQ: begin
					if (held_none) begin
						r.status = qufi_pkg::ST_EMPTY;
					end else begin
						r.out_id = slot_mem[head_idx];
						if (head_idx == tail_idx) begin
							head_idx  = 0;
							tail_idx  = 0;
							held_none = 1'b1;
						end else begin
							head_idx++;
						end
					end
				end
				default: begin
					if (held_none)
						r.status = qufi_pkg::ST_EMPTY;
					else
						r.out_id = slot_mem[head_idx];
				end
			endcase
			r.entry_count = held_none ? 8'd0 : 8'(tail_idx - head_idx + 1);
			awaited_results.push_back(r);
		endfunction

		task check_result(qufi_pkg::result_t got);
			qufi_pkg::result_t want;
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %p", got));
			end else begin
				want = awaited_results.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d",
						got.status, want.status));
				if (got.out_id !== want.out_id)
					report_mismatch($sformatf("out_id %h, want %h",
						got.out_id, want.out_id));
				if (got.entry_count !== want.entry_count)
					report_mismatch($sformatf("entry_count %0d, want %0d",
						got.entry_count, want.entry_count));
			end
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	qufi_pkg::item_t   item;
	logic              done;
	qufi_pkg::result_t result;

	front_queue_predictor queue_model;
	int unsigned          words_taken = 0;

	queue_with_urgent_front_insert #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.done  (done),
		.result(result)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Observe both handshakes at the rising edge. A word is taken on start
	// high with busy low; a result lives for exactly one cycle under done.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				queue_model.check_result(result);
			if (start && !busy) begin
				queue_model.note_command(item);
				words_taken++;
			end
		end
	end

	// Present one word at the falling edge and hold it until the block takes
	// it. Returns on the falling edge right after acceptance with start still
	// high, so a follow-on word keeps start asserted without a glitch.
	task send_word(logic [1:0] cmd, logic [15:0] id);
		int unsigned taken_before;
		taken_before = words_taken;
		start        <= 1'b1;
		item.cmd     <= cmd;
		item.item_id <= id;
		do
			@(negedge clk);
		while (words_taken == taken_before);
	endtask

	task idle_cycles(int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Hold off the sender until the block has answered everything in flight.
	task drain_results();
		start <= 1'b0;
		do
			@(negedge clk);
		while (queue_model.pending() != 0);
	endtask

	function logic [15:0] random_id();
		case ($urandom_range(0, 9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	// Command mix per phase flavor, in percent: enqueue / urgent / dequeue / peek.
	function logic [1:0] pick_cmd(mix_e mix);
		int unsigned roll;
		int unsigned enq_pct, urg_pct, deq_pct;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:   begin enq_pct = 60; urg_pct = 25; deq_pct = 10; end
			MIX_DRAIN:  begin enq_pct = 15; urg_pct = 10; deq_pct = 60; end
			MIX_URGENT: begin enq_pct = 15; urg_pct = 55; deq_pct = 20; end
			default:    begin enq_pct = 25; urg_pct = 25; deq_pct = 25; end
		endcase
		if (roll < enq_pct)
			return qufi_pkg::CMD_ENQ;
		else if (roll < enq_pct + urg_pct)
			return qufi_pkg::CMD_URG;
		else if (roll < enq_pct + urg_pct + deq_pct)
			return qufi_pkg::CMD_DEQ;
		else
			return qufi_pkg::CMD_PEEK;
	endfunction

	initial begin
		mix_e        mix;
		int          sent;
		int          phase_len;
		int          burst_left;
		bit          gappy;

		queue_model  = new();
		arst_n       = 1'b0;
		start        = 1'b0;
		item         = '0;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// --- directed part ---
		// empty queue: dequeue and peek both report empty, the ID is ignored
		send_word(qufi_pkg::CMD_PEEK, 16'hFFFF);
		send_word(qufi_pkg::CMD_DEQ,  16'h0000);
		// front insert into an empty queue, then drain the single entry,
		// which returns both indices to zero
		send_word(qufi_pkg::CMD_URG,  16'hFFFF);
		send_word(qufi_pkg::CMD_PEEK, 16'h5A5A);
		send_word(qufi_pkg::CMD_DEQ,  16'hFFFF);
		send_word(qufi_pkg::CMD_DEQ,  16'h1234);
		// rear inserts with extreme IDs
		send_word(qufi_pkg::CMD_ENQ,  16'h0000);
		send_word(qufi_pkg::CMD_ENQ,  16'hFFFF);
		send_word(qufi_pkg::CMD_ENQ,  16'h8001);
		// head at slot 0: the urgent insert must shift every entry
		send_word(qufi_pkg::CMD_URG,  16'h7FFE);
		send_word(qufi_pkg::CMD_PEEK, 16'h0000);
		send_word(qufi_pkg::CMD_DEQ,  16'h0000);
		// a front slot is free now: urgent insert reuses it
		send_word(qufi_pkg::CMD_URG,  16'hC3C3);
		send_word(qufi_pkg::CMD_DEQ,  16'h0000);
		send_word(qufi_pkg::CMD_DEQ,  16'h0000);
		drain_results();
		send_word(qufi_pkg::CMD_DEQ,  16'h0000);
		send_word(qufi_pkg::CMD_DEQ,  16'h0000);
		send_word(qufi_pkg::CMD_DEQ,  16'h0000);
		send_word(qufi_pkg::CMD_PEEK, 16'h0000);
		// sender pauses until every outstanding result has come back
		drain_results();

		// --- random part ---
		// Phases with a biased mix: fill phases run the tail into the last
		// slot (full, often with freed front slots), drain phases empty it.
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			mix        = mix_e'($urandom_range(0, 3));
			phase_len  = $urandom_range(20, 150);
			gappy      = ($urandom_range(0, 2) != 0);
			burst_left = $urandom_range(1, 30);
			for (int k = 0; k < phase_len && sent < RANDOM_WORDS; k++) begin
				send_word(pick_cmd(mix), random_id());
				sent++;
				if (gappy) begin
					burst_left--;
					if (burst_left == 0) begin
						idle_cycles($urandom_range(1, 8));
						burst_left = $urandom_range(1, 30);
					end
				end
			end
			if ($urandom_range(0, 3) == 0)
				drain_results();
		end

		// --- wind-down ---
		drain_results();
		// leave room for a stray strobe after the last expected result
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (queue_model.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run (every word a full shift).
	initial begin
		#30ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/qufi_pkg.sv
rtl/core/qufi_ctrl.sv
rtl/core/qufi_dpath.sv
rtl/core/queue_with_urgent_front_insert.sv
dv/testbench.sv
